// ----- hw/rtl/tofe_pkg.sv -----
// Shared types and constants for the on-off-keyed frame encoder.
package tofe_pkg;

  localparam int unsigned NIBBLES = 7;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  localparam logic [7:0] SYNC_HI0_START = 8'd3;
  localparam logic [7:0] SYNC_HI0_END   = 8'd6;
  localparam logic [7:0] SYNC_HI1_START = 8'd9;
  localparam logic [7:0] SYNC_END       = 8'd12;
  localparam logic [7:0] DATA_END       = 8'd180;
  localparam logic [7:0] FRAME_LAST     = 8'd185;

  localparam logic [3:0] NIB_ZERO = 4'h0;
  localparam logic [3:0] NIB_ONES = 4'hF;

  localparam logic [3:0] REPEAT_RESET = 4'd8;

  typedef enum logic [1:0] {
    SRC_ZERO = 2'd0,
    SRC_ONE  = 2'd1,
    SRC_DATA = 2'd2
  } chip_src_e;

  typedef enum logic [1:0] {
    PH_LEAD = 2'd0,
    PH_DATA = 2'd1,
    PH_TAIL = 2'd2
  } phase_e;

  typedef struct packed {
    logic      busy;
    chip_src_e src;
    logic      shift;
    logic      last;
  } tofe_ctrl_t;

endpackage

// ----- hw/rtl/tofe_if.sv -----
// Channel interfaces: input requests, result requests and the configuration write.
interface tofe_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [19:0] address;
  logic        heat_on;
  logic        pair_mode;
  modport source (output valid, cmd, address, heat_on, pair_mode, input ready);
  modport sink   (input valid, cmd, address, heat_on, pair_mode, output ready);
endinterface

interface tofe_out_if;
  logic valid;
  logic ready;
  logic chip;
  logic active;
  logic last;
  modport source (output valid, chip, active, last, input ready);
  modport sink   (input valid, chip, active, last, output ready);
endinterface

interface tofe_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] repeat_count;
  modport source (output valid, repeat_count, input ready);
  modport sink   (input valid, repeat_count, output ready);
endinterface

// ----- hw/rtl/tofe_cell.sv -----
// One nibble cell of the circular data shift chain.
module tofe_cell
  import tofe_pkg::*;
(
  input  logic       clk_i,
  input  logic       load_i,
  input  logic       shift_i,
  input  logic [3:0] load_nib_i,
  input  logic       ser_i,
  output logic       msb_o
);

  logic [3:0] nib_q;
  logic [3:0] nib_d;

  always_comb begin
    nib_d = nib_q;
    if (load_i) begin
      nib_d = load_nib_i;
    end else if (shift_i) begin
      nib_d = {nib_q[2:0], ser_i};
    end
  end

  always_ff @(posedge clk_i) begin
    nib_q <= nib_d;
  end

  assign msb_o = nib_q[3];

endmodule

// ----- hw/rtl/tofe_seq.sv -----
// Frame sequencer: chip position, bit phase, repeat counter and busy flag.
module tofe_seq
  import tofe_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic       adv_i,
  input  logic [3:0] repeat_count_i,
  output tofe_ctrl_t ctrl_o
);

  logic [7:0] pos_q, pos_d;
  phase_e     phase_q, phase_d;
  logic [3:0] rep_q, rep_d;
  logic       busy_q, busy_d;
  logic       last_frame;
  logic       frame_end;
  logic       in_data;

  assign in_data    = (pos_q >= SYNC_END) && (pos_q < DATA_END);
  assign frame_end  = (pos_q == FRAME_LAST);
  // A count of zero behaves as a single frame.
  assign last_frame = (repeat_count_i == 4'd0) || (rep_q >= (repeat_count_i - 4'd1));

  always_comb begin
    ctrl_o.busy  = busy_q;
    ctrl_o.shift = in_data && (phase_q == PH_TAIL);
    ctrl_o.last  = frame_end && last_frame;
    ctrl_o.src   = SRC_ZERO;
    if (pos_q < SYNC_END) begin
      if (((pos_q >= SYNC_HI0_START) && (pos_q < SYNC_HI0_END)) ||
          (pos_q >= SYNC_HI1_START)) begin
        ctrl_o.src = SRC_ONE;
      end
    end else if (in_data) begin
      unique case (phase_q)
        PH_LEAD: ctrl_o.src = SRC_ZERO;
        PH_DATA: ctrl_o.src = SRC_DATA;
        PH_TAIL: ctrl_o.src = SRC_ONE;
        default: ctrl_o.src = SRC_ZERO;
      endcase
    end
  end

  always_comb begin
    pos_d   = pos_q;
    phase_d = phase_q;
    rep_d   = rep_q;
    busy_d  = busy_q;
    if (start_i) begin
      pos_d   = 8'd0;
      phase_d = PH_LEAD;
      rep_d   = 4'd0;
      busy_d  = 1'b1;
    end else if (adv_i) begin
      if (frame_end) begin
        pos_d   = 8'd0;
        phase_d = PH_LEAD;
        if (last_frame) begin
          rep_d  = 4'd0;
          busy_d = 1'b0;
        end else begin
          rep_d = rep_q + 4'd1;
        end
      end else begin
        pos_d = pos_q + 8'd1;
        unique case (phase_q)
          PH_LEAD: phase_d = PH_DATA;
          PH_DATA: phase_d = PH_TAIL;
          PH_TAIL: phase_d = PH_LEAD;
          default: phase_d = PH_LEAD;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= 8'd0;
      phase_q <= PH_LEAD;
      rep_q   <= 4'd0;
      busy_q  <= 1'b0;
    end else begin
      pos_q   <= pos_d;
      phase_q <= phase_d;
      rep_q   <= rep_d;
      busy_q  <= busy_d;
    end
  end

  a_pos_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= FRAME_LAST)
    else $error("chip position left the frame");

  a_idle_at_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> (pos_q == 8'd0) && (rep_q == 4'd0))
    else $error("counters not cleared while idle");

  // The bit phase is the chip position modulo three.
  a_phase_tracks_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv_i && !start_i && !frame_end && (phase_q == PH_TAIL)) |=> (phase_q == PH_LEAD))
    else $error("phase did not wrap after a bit");

endmodule

// ----- hw/rtl/thermostat_ook_frame_encoder_unit.sv -----
// Top level of the on-off-keyed remote frame encoder.
// A start request (cmd 0) taken while idle latches the address and flags and
// produces no result; a start while a transmission runs is dropped. Every
// tick request (cmd 1) produces one result holding the next line chip, with
// active low and chip low when no transmission runs. A transmission is
// repeat_count frames of 186 chips (sync, seven nibbles sent twice with
// three chips per bit, stop), and last marks its final chip. One request is
// taken per clock: the chip comes from the frame counters and the head of a
// seven-cell nibble shift chain, and a single output register carries the
// result, so the input stays ready whenever that register is empty or being
// drained. The result of a tick request is registered and appears in the cycle
// after that request. repeat_count may only be written while no transmission runs.
module thermostat_ook_frame_encoder_unit
  import tofe_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  tofe_in_if.sink     in_i,
  tofe_out_if.source  out_o,
  tofe_cfg_if.sink    cfg_i
);

  logic [3:0]         repeat_count_q;
  logic               out_valid_q, out_valid_d;
  logic               chip_q, chip_d;
  logic               active_q, active_d;
  logic               last_q, last_d;
  logic               in_fire;
  logic               start_req;
  logic               tick_adv;
  tofe_ctrl_t         ctrl;
  logic [NIBBLES-1:0] msb;
  logic [3:0]         load_nib [NIBBLES];

  assign in_i.ready  = !out_valid_q || out_o.ready;
  assign cfg_i.ready = 1'b1;
  assign in_fire     = in_i.valid && in_i.ready;
  assign start_req   = in_fire && (in_i.cmd == CMD_START) && !ctrl.busy;
  assign tick_adv    = in_fire && (in_i.cmd == CMD_TICK) && ctrl.busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      repeat_count_q <= REPEAT_RESET;
    end else if (cfg_i.valid) begin
      repeat_count_q <= cfg_i.repeat_count;
    end
  end

  tofe_seq u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_req),
    .adv_i          (tick_adv),
    .repeat_count_i (repeat_count_q),
    .ctrl_o         (ctrl)
  );

  assign load_nib[0] = in_i.address[19:16];
  assign load_nib[1] = in_i.address[15:12];
  assign load_nib[2] = in_i.address[11:8];
  assign load_nib[3] = in_i.address[7:4];
  assign load_nib[4] = in_i.address[3:0];
  assign load_nib[5] = (in_i.heat_on && !in_i.pair_mode) ? NIB_ZERO : NIB_ONES;
  assign load_nib[6] = in_i.pair_mode ? NIB_ONES : NIB_ZERO;

  // The chain is closed into a ring, so after 28 shifts it holds the message again.
  for (genvar i = 0; i < NIBBLES; i++) begin : g_cell
    tofe_cell u_cell (
      .clk_i      (clk_i),
      .load_i     (start_req),
      .shift_i    (tick_adv && ctrl.shift),
      .load_nib_i (load_nib[i]),
      .ser_i      (msb[(i + 1) % NIBBLES]),
      .msb_o      (msb[i])
    );
  end

  always_comb begin
    out_valid_d = out_valid_q;
    chip_d      = chip_q;
    active_d    = active_q;
    last_d      = last_q;
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (in_fire && (in_i.cmd == CMD_TICK)) begin
      out_valid_d = 1'b1;
      active_d    = ctrl.busy;
      last_d      = ctrl.busy && ctrl.last;
      chip_d      = 1'b0;
      if (ctrl.busy) begin
        unique case (ctrl.src)
          SRC_ZERO: chip_d = 1'b0;
          SRC_ONE:  chip_d = 1'b1;
          SRC_DATA: chip_d = msb[0];
          default:  chip_d = 1'b0;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chip_q   <= chip_d;
    active_q <= active_d;
    last_q   <= last_d;
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.chip   = chip_q;
  assign out_o.active = active_q;
  assign out_o.last   = last_q;

  a_idle_tick_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (in_i.cmd == CMD_TICK) && !ctrl.busy) |=>
      (out_valid_q && !active_q && !chip_q && !last_q))
    else $error("idle tick produced an active result");

  a_last_ends_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tick_adv && ctrl.last) |=> !ctrl.busy)
    else $error("transmission continued after its final chip");

  a_start_sets_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_req |=> ctrl.busy)
    else $error("accepted start did not begin a transmission");

endmodule
